// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same, on the usual clock and reset names.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/tis_pkg.sv =====
`timescale 1ns / 1ps
package tis_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W_IN      = 26;
  localparam int W_N       = 12;
  localparam int W_IN_DATA = 2 * W_IN + W_N;
  localparam int DIV_BITS  = W_IN + 1;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  localparam int W_SQ      = 2 * DIV_BITS;
  localparam int W_S       = 64;
  localparam int W_HALF    = W_S / 2;
  localparam int W_PP      = DIV_BITS + W_HALF;
  localparam int W_FULL    = DIV_BITS + W_S;
  localparam int OUT_SHIFT = 2 * FRAC_BITS + 1;
  localparam int W_OUT     = 64;
  localparam int PC_W      = 4;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_SQ_LO,
    OP_SQ_UP,
    OP_ACC_UP,
    OP_PRIME,
    OP_LOOP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMBINE,
    OP_ROUND,
    OP_SIGN,
    OP_ERR
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_START,
    COND_DIV_MORE,
    COND_I_DONE,
    COND_I_MORE,
    COND_OUT_WAIT
  } cond_e;

  localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_STEP = PC_W'(2);
  localparam logic [PC_W-1:0] PC_LOOP     = PC_W'(8);
  localparam logic [PC_W-1:0] PC_MUL_LO   = PC_W'(9);
  localparam logic [PC_W-1:0] PC_ERR      = PC_W'(14);

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic start;     // input transaction this cycle
    logic n_zero;    // its step count is zero
    logic div_more;  // divider has iterations left
    logic i_done;    // all interior points issued
    logic out_busy;  // output register full and stalled
  } status_t;

  // Microprogram: one control word per step.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_W'(0):  w = '{OP_IDLE,     COND_START,    PC_ERR};
      PC_W'(1):  w = '{OP_DIV_INIT, COND_NEXT,     PC_IDLE};
      PC_W'(2):  w = '{OP_DIV_STEP, COND_DIV_MORE, PC_DIV_STEP};
      PC_W'(3):  w = '{OP_DIV_END,  COND_NEXT,     PC_IDLE};
      PC_W'(4):  w = '{OP_SQ_LO,    COND_NEXT,     PC_IDLE};
      PC_W'(5):  w = '{OP_SQ_UP,    COND_NEXT,     PC_IDLE};
      PC_W'(6):  w = '{OP_ACC_UP,   COND_NEXT,     PC_IDLE};
      PC_W'(7):  w = '{OP_PRIME,    COND_I_DONE,   PC_MUL_LO};
      PC_W'(8):  w = '{OP_LOOP,     COND_I_MORE,   PC_LOOP};
      PC_W'(9):  w = '{OP_MUL_LO,   COND_NEXT,     PC_IDLE};
      PC_W'(10): w = '{OP_MUL_HI,   COND_NEXT,     PC_IDLE};
      PC_W'(11): w = '{OP_COMBINE,  COND_NEXT,     PC_IDLE};
      PC_W'(12): w = '{OP_ROUND,    COND_NEXT,     PC_IDLE};
      PC_W'(13): w = '{OP_SIGN,     COND_OUT_WAIT, PC_IDLE};
      PC_W'(14): w = '{OP_ERR,      COND_OUT_WAIT, PC_IDLE};
      default:   w = '{OP_IDLE,     COND_START,    PC_ERR};
    endcase
    return w;
  endfunction

endpackage

// ===== design/tis_useq.sv =====
`timescale 1ns / 1ps
module tis_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tis_pkg::status_t  status_i,
  output tis_pkg::ctrl_t    ctrl_o
);
  import tis_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;

  assign uw        = ucode_rom(pc_q);
  assign ctrl_o.op = uw.op;

  always_comb begin
    pc_d = pc_q + PC_W'(1);
    unique case (uw.cond)
      COND_NEXT: ;
      COND_START: begin
        if (!status_i.start) begin
          pc_d = pc_q;
        end else if (status_i.n_zero) begin
          pc_d = uw.target;
        end
      end
      COND_DIV_MORE: begin
        if (status_i.div_more) pc_d = uw.target;
      end
      COND_I_DONE: begin
        if (status_i.i_done) pc_d = uw.target;
      end
      COND_I_MORE: begin
        if (!status_i.i_done) pc_d = uw.target;
      end
      COND_OUT_WAIT: begin
        pc_d = status_i.out_busy ? pc_q : uw.target;
      end
      default: pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== design/tis_datapath.sv =====
`timescale 1ns / 1ps
module tis_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tis_pkg::ctrl_t                  ctrl_i,
  output tis_pkg::status_t                status_o,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [tis_pkg::W_IN_DATA-1:0]   s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [tis_pkg::W_OUT-1:0]       m_tdata_o,
  output logic                            m_tuser_o
);
  import tis_pkg::*;

  op_e                  op;
  logic                 accept;
  logic                 out_busy;
  logic                 out_load;
  logic [W_N-1:0]       in_n;

  logic [W_IN-1:0]      lo_q, up_q;
  logic [W_N-1:0]       n_q;
  logic [DIV_BITS-1:0]  quo_q, hmag_q, h_q, x_q;
  logic [W_N-1:0]       div_rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 dneg_q, neg_q;
  logic [W_N-1:0]       i_q;
  logic [W_SQ-1:0]      p_q;
  logic [W_S-1:0]       s_q;
  logic [W_PP-1:0]      pp_lo_q, pp_hi_q;
  logic [W_FULL-1:0]    full_q;
  logic                 sticky_q;
  logic [W_OUT-1:0]     q_q;
  logic                 m_valid_q;
  logic [W_OUT-1:0]     integral_q;
  logic                 error_q;

  logic [DIV_BITS-1:0]  lo_ext, up_ext, diff, diff_mag, xmag;
  logic [W_N:0]         div_sh, div_sub;
  logic                 div_ge;
  logic [W_SQ-1:0]      sq;
  logic [W_HALF-1:0]    s_half;
  logic [W_PP-1:0]      pp;
  logic [W_FULL-1:0]    full_sum;

  assign op         = ctrl_i.op;
  assign s_tready_o = (op == OP_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign in_n       = s_tdata_i[2*W_IN +: W_N];
  assign out_busy   = m_valid_q && !m_tready_i;
  assign out_load   = ((op == OP_SIGN) || (op == OP_ERR)) && !out_busy;

  assign status_o.start    = accept;
  assign status_o.n_zero   = (in_n == '0);
  assign status_o.div_more = (div_cnt_q != DIV_CNT_W'(DIV_BITS - 1));
  assign status_o.i_done   = (i_q == n_q);
  assign status_o.out_busy = out_busy;

  assign lo_ext   = {lo_q[W_IN-1], lo_q};
  assign up_ext   = {up_q[W_IN-1], up_q};
  assign diff     = up_ext - lo_ext;
  assign diff_mag = diff[DIV_BITS-1] ? (~diff + DIV_BITS'(1)) : diff;

  // restoring divide, one quotient bit per step
  assign div_sh  = {div_rem_q, quo_q[DIV_BITS-1]};
  assign div_ge  = (div_sh >= {1'b0, n_q});
  assign div_sub = div_sh - {1'b0, n_q};

  assign xmag = x_q[DIV_BITS-1] ? (~x_q + DIV_BITS'(1)) : x_q;
  assign sq   = xmag * xmag;

  // |h| * s split into two 32-bit halves of s
  assign s_half   = (op == OP_MUL_LO) ? s_q[W_HALF-1:0] : s_q[W_S-1:W_HALF];
  assign pp       = hmag_q * s_half;
  assign full_sum = W_FULL'(pp_lo_q) + {pp_hi_q, W_HALF'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      div_cnt_q <= '0;
      i_q       <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (op == OP_DIV_INIT) div_cnt_q <= '0;
      if (op == OP_DIV_STEP) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (op == OP_ACC_UP) i_q <= W_N'(1);
      if (((op == OP_PRIME) || (op == OP_LOOP)) && !status_o.i_done) begin
        i_q <= i_q + W_N'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op)
      OP_IDLE: begin
        if (accept) begin
          lo_q <= s_tdata_i[0 +: W_IN];
          up_q <= s_tdata_i[W_IN +: W_IN];
          n_q  <= in_n;
        end
      end
      OP_DIV_INIT: begin
        quo_q     <= diff_mag;
        div_rem_q <= '0;
        dneg_q    <= diff[DIV_BITS-1];
      end
      OP_DIV_STEP: begin
        quo_q     <= {quo_q[DIV_BITS-2:0], div_ge};
        div_rem_q <= div_ge ? div_sub[W_N-1:0] : div_sh[W_N-1:0];
      end
      OP_DIV_END: begin
        hmag_q <= quo_q;
        h_q    <= dneg_q ? (~quo_q + DIV_BITS'(1)) : quo_q;
        neg_q  <= dneg_q;
        x_q    <= lo_ext;
      end
      OP_SQ_LO: begin
        p_q <= sq;
        s_q <= '0;
        x_q <= up_ext;
      end
      OP_SQ_UP: begin
        s_q <= s_q + W_S'(p_q);
        p_q <= sq;
      end
      OP_ACC_UP: begin
        s_q <= s_q + W_S'(p_q);
        x_q <= lo_ext + h_q;
      end
      OP_PRIME: begin
        if (!status_o.i_done) begin
          p_q <= sq;
          x_q <= x_q + h_q;
        end
      end
      OP_LOOP: begin
        // interior points count twice
        s_q <= s_q + W_S'({p_q, 1'b0});
        if (!status_o.i_done) begin
          p_q <= sq;
          x_q <= x_q + h_q;
        end
      end
      OP_MUL_LO: pp_lo_q <= pp;
      OP_MUL_HI: pp_hi_q <= pp;
      OP_COMBINE: begin
        full_q   <= full_sum;
        sticky_q <= |full_sum[OUT_SHIFT-1:0];
      end
      OP_ROUND: begin
        // floor of a negative value: bump the magnitude when bits fall off
        q_q <= W_OUT'(full_q[W_FULL-1:OUT_SHIFT]) + W_OUT'(neg_q & sticky_q);
      end
      OP_SIGN: begin
        if (!out_busy) begin
          integral_q <= neg_q ? (~q_q + W_OUT'(1)) : q_q;
          error_q    <= 1'b0;
        end
      end
      OP_ERR: begin
        if (!out_busy) begin
          integral_q <= '0;
          error_q    <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = integral_q;
  assign m_tuser_o  = error_q;

endmodule

// ===== design/trapezoid_integral_of_square.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                               tuser
// s_axis    in   lower_bound[25:0] upper_bound[51:26] step_count[63:52]  -
// m_axis    out  integral[63:0]                                   error[0]
//
// A request needs h from the 27 iterations of the restoring divider and one
// pass per interior point through the single 27x27 squarer in the microcode loop.
// Reset (asynchronous, active low) returns the step counter to idle and empties
// the result register. A stalled result holds; the next request is taken while
// it waits, and the program waits at its last step until the register is free.
module trapezoid_integral_of_square (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lower_bound, upper_bound, step_count
  input  logic [tis_pkg::W_IN_DATA-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // integral
  output logic [tis_pkg::W_OUT-1:0]     m_axis_tdata,
  // error
  output logic                          m_axis_tuser
);
  import tis_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  tis_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tis_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

// ===== design/tis_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tis_pkg::W_OUT-1:0]     m_axis_tdata,
  input logic                          m_axis_tuser
);
  import tis_pkg::*;

  logic in_txn;
  logic out_stall;

  assign in_txn    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `ASSERT_STD(a_out_hold_valid, out_stall |=> m_axis_tvalid)
  `ASSERT_STD(a_out_hold_data, out_stall |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // error results carry a zero integral
  `ASSERT_STD(a_err_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
  // one request at a time: after a transaction the input side closes
  `ASSERT_STD(a_busy_after_txn, in_txn |=> !s_axis_tready)

endmodule

bind trapezoid_integral_of_square tis_checker u_tis_checker (.*);
